@@ src/tbn_pkg.sv @@
// constants, codes and types for the debounced button track selector
// no dependencies; used by track_button_navigator
`default_nettype none

package tbn_pkg;

  localparam int MAX_TRACKS = 128;
  localparam int TRACK_W    = $clog2(MAX_TRACKS);
  localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
  localparam int IDX_W      = 7;
  localparam int TIMER_W    = 16;
  localparam int TC_W       = 8;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  localparam logic LEVEL_HIGH = 1'b1;

  localparam logic [TIMER_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [TIMER_W-1:0] WINDOW_RST   = 16'd3000;
  localparam logic [TC_W-1:0]    TCOUNT_RST   = 8'd1;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_WINDOW   = 2'd1;
  localparam logic [1:0] REG_TCOUNT   = 2'd2;

  typedef logic [1:0] pact_t;

  localparam pact_t PACT_NONE    = 2'd0;
  localparam pact_t PACT_STEP    = 2'd1;
  localparam pact_t PACT_RESTART = 2'd2;

  typedef logic [TIMER_W-1:0] timer_t;
  typedef logic [TRACK_W-1:0] track_t;
  typedef logic [CNT_W-1:0]   count_t;

  function automatic timer_t sat_inc(input timer_t t);
    sat_inc = (t == TIMER_MAX) ? t : t + 1'b1;
  endfunction

endpackage

`default_nettype wire

@@ src/track_button_navigator.sv @@
// debounced previous/next button track selector, top level
// depends on tbn_pkg
//
// usage: one input transfer per millisecond tick carries the raw active-low
// levels of the previous and next buttons (in_prev_level, in_next_level).
// each input transfer yields exactly one output transfer with the previous
// action (none, step back, restart), the next action and the track index.
// out_valid rises in the cycle after the input transfer; throughput is one tick
// per cycle without a receiver stall, set by the single output register that holds the result.
// in_ready is high whenever the output register is empty or being taken, so
// a receiver stall holds the result and stalls the input side only then.
// configuration: apb write at 0x0 debounce, 0x4 restart window, 0x8 track
// count; reads return the register values; pready is always high.
// reset (rst_n low, synchronous) restores register defaults (50, 3000, 1),
// marks both buttons released, clears the timers and the track index and
// empties the output register.
`default_nettype none

module track_button_navigator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_prev_level,
  input  wire logic                       in_next_level,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output tbn_pkg::pact_t                  out_prev_action,
  output logic                            out_next_action,
  output logic [tbn_pkg::IDX_W-1:0]       out_track_index,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tbn_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tbn_pkg::DATA_W-1:0] pwdata,
  output logic [tbn_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  tbn_pkg::timer_t debounce_r, window_r;
  logic [tbn_pkg::TC_W-1:0] tcount_r;

  logic prev_raw_r, prev_stable_r, next_raw_r, next_stable_r;
  tbn_pkg::timer_t prev_timer_r, next_timer_r, play_timer_r;
  tbn_pkg::track_t track_r;

  logic out_valid_r;
  tbn_pkg::pact_t out_pact_r;
  logic out_nact_r;
  logic [tbn_pkg::IDX_W-1:0] out_idx_r;

  logic prev_raw_nxt, prev_stable_nxt, next_raw_nxt, next_stable_nxt;
  tbn_pkg::timer_t prev_timer_nxt, next_timer_nxt, play_timer_nxt;
  tbn_pkg::track_t track_nxt, track_mid;
  tbn_pkg::pact_t pact_nxt;
  logic nact_nxt;
  tbn_pkg::count_t count;
  logic in_xfer, cfg_wr;
  logic [1:0] reg_idx;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[3:2];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign out_valid       = out_valid_r;
  assign out_prev_action = out_pact_r;
  assign out_next_action = out_nact_r;
  assign out_track_index = out_idx_r;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      tbn_pkg::REG_DEBOUNCE: prdata = tbn_pkg::DATA_W'(debounce_r);
      tbn_pkg::REG_WINDOW:   prdata = tbn_pkg::DATA_W'(window_r);
      tbn_pkg::REG_TCOUNT:   prdata = tbn_pkg::DATA_W'(tcount_r);
      default:               prdata = '0;
    endcase
  end

  // effective track count, clamped to one..MAX_TRACKS
  always_comb begin
    if (tcount_r == '0) begin
      count = tbn_pkg::count_t'(1);
    end else if (32'(tcount_r) > tbn_pkg::MAX_TRACKS) begin
      count = tbn_pkg::count_t'(tbn_pkg::MAX_TRACKS);
    end else begin
      count = tbn_pkg::count_t'(tcount_r);
    end
  end

  always_comb begin
    prev_timer_nxt  = tbn_pkg::sat_inc(prev_timer_r);
    next_timer_nxt  = tbn_pkg::sat_inc(next_timer_r);
    play_timer_nxt  = tbn_pkg::sat_inc(play_timer_r);
    prev_stable_nxt = prev_stable_r;
    next_stable_nxt = next_stable_r;
    prev_raw_nxt    = in_prev_level;
    next_raw_nxt    = in_next_level;
    pact_nxt        = tbn_pkg::PACT_NONE;
    nact_nxt        = 1'b0;
    track_mid       = track_r;

    // previous button
    if (in_prev_level != prev_raw_r) begin
      prev_timer_nxt = '0;
    end
    if (prev_timer_nxt >= debounce_r && in_prev_level != prev_stable_r) begin
      prev_stable_nxt = in_prev_level;
      if (in_prev_level == tbn_pkg::LEVEL_HIGH) begin
        if (play_timer_nxt <= window_r) begin
          if (track_r == '0 || tbn_pkg::count_t'(track_r) >= count) begin
            track_mid = tbn_pkg::track_t'(count - 1'b1);
          end else begin
            track_mid = track_r - 1'b1;
          end
          pact_nxt = tbn_pkg::PACT_STEP;
        end else begin
          pact_nxt = tbn_pkg::PACT_RESTART;
        end
        play_timer_nxt = '0;
        prev_timer_nxt = '0;
      end
    end

    // next button
    track_nxt = track_mid;
    if (in_next_level != next_raw_r) begin
      next_timer_nxt = '0;
    end
    if (next_timer_nxt >= debounce_r && in_next_level != next_stable_r) begin
      next_stable_nxt = in_next_level;
      if (in_next_level == tbn_pkg::LEVEL_HIGH) begin
        next_timer_nxt = '0;
        if (tbn_pkg::count_t'(track_mid) + 1'b1 >= count) begin
          track_nxt = '0;
        end else begin
          track_nxt = track_mid + 1'b1;
        end
        nact_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= tbn_pkg::DEBOUNCE_RST;
      window_r   <= tbn_pkg::WINDOW_RST;
      tcount_r   <= tbn_pkg::TCOUNT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        tbn_pkg::REG_DEBOUNCE: debounce_r <= pwdata[tbn_pkg::TIMER_W-1:0];
        tbn_pkg::REG_WINDOW:   window_r   <= pwdata[tbn_pkg::TIMER_W-1:0];
        tbn_pkg::REG_TCOUNT:   tcount_r   <= pwdata[tbn_pkg::TC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r    <= tbn_pkg::LEVEL_HIGH;
      prev_stable_r <= tbn_pkg::LEVEL_HIGH;
      next_raw_r    <= tbn_pkg::LEVEL_HIGH;
      next_stable_r <= tbn_pkg::LEVEL_HIGH;
      prev_timer_r  <= '0;
      next_timer_r  <= '0;
      play_timer_r  <= '0;
      track_r       <= '0;
    end else if (in_xfer) begin
      prev_raw_r    <= prev_raw_nxt;
      prev_stable_r <= prev_stable_nxt;
      next_raw_r    <= next_raw_nxt;
      next_stable_r <= next_stable_nxt;
      prev_timer_r  <= prev_timer_nxt;
      next_timer_r  <= next_timer_nxt;
      play_timer_r  <= play_timer_nxt;
      track_r       <= track_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_pact_r <= pact_nxt;
      out_nact_r <= nact_nxt;
      out_idx_r  <= tbn_pkg::IDX_W'(track_nxt);
    end
  end

  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("input transfer did not load a result");

  a_prev_clears_timers: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && pact_nxt != tbn_pkg::PACT_NONE) |=>
      (play_timer_r == '0 && prev_timer_r == '0 && prev_stable_r == tbn_pkg::LEVEL_HIGH))
    else $error("previous action did not clear play and previous timers");

  a_next_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && nact_nxt) |=> (next_timer_r == '0 && out_nact_r))
    else $error("next action did not clear next timer");

  a_track_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (pact_nxt == tbn_pkg::PACT_STEP || nact_nxt)) |->
      tbn_pkg::count_t'(track_nxt) < count)
    else $error("stepped track index out of range");

endmodule

`default_nettype wire

@@ test/track_nav_check.sv @@
`timescale 1ns / 1ps
// checker for track_button_navigator: follows tick, result and apb transfers,
// predicts each result from its own debounce and track state; uses tbn_pkg
module track_nav_check (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_prev_level,
  input  logic                       in_next_level,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  tbn_pkg::pact_t             out_prev_action,
  input  logic                       out_next_action,
  input  logic [tbn_pkg::IDX_W-1:0]  out_track_index,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tbn_pkg::ADDR_W-1:0] paddr,
  input  logic [tbn_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  output int                         err_count,
  output int                         pending,
  output int                         results_checked,
  output int                         steps_back,
  output int                         restarts,
  output int                         steps_fwd
);

  typedef struct packed {
    tbn_pkg::pact_t                prev_action;
    logic                          next_action;
    logic [tbn_pkg::IDX_W-1:0]     track_index;
  } tick_result_t;

  tbn_pkg::timer_t dbnc_ms;
  tbn_pkg::timer_t window_ms;
  logic [7:0]      tcount;

  logic            prev_raw;
  logic            prev_stable;
  tbn_pkg::timer_t prev_tmr;
  logic            next_raw;
  logic            next_stable;
  tbn_pkg::timer_t next_tmr;
  tbn_pkg::timer_t play_tmr;
  int unsigned     track;

  tick_result_t results_due[$];
  tick_result_t want;

  initial begin
    err_count       = 0;
    pending         = 0;
    results_checked = 0;
    steps_back      = 0;
    restarts        = 0;
    steps_fwd       = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (err_count < 20) begin
      $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, exp_val);
    end
    err_count++;
  endtask

  function automatic tick_result_t next_track_result(input logic praw, input logic nraw);
    tick_result_t r;
    int unsigned  cnt;
    cnt = (tcount == 0) ? 1 : ((tcount > tbn_pkg::MAX_TRACKS) ? tbn_pkg::MAX_TRACKS : tcount);
    r.prev_action = tbn_pkg::PACT_NONE;
    r.next_action = 1'b0;
    prev_tmr = (prev_tmr == tbn_pkg::TIMER_MAX) ? prev_tmr : prev_tmr + 1'b1;
    next_tmr = (next_tmr == tbn_pkg::TIMER_MAX) ? next_tmr : next_tmr + 1'b1;
    play_tmr = (play_tmr == tbn_pkg::TIMER_MAX) ? play_tmr : play_tmr + 1'b1;

    if (praw != prev_raw) prev_tmr = '0;
    if (prev_tmr >= dbnc_ms && praw != prev_stable) begin
      prev_stable = praw;
      if (praw == tbn_pkg::LEVEL_HIGH) begin
        if (play_tmr <= window_ms) begin
          track = (track == 0 || track >= cnt) ? cnt - 1 : track - 1;
          r.prev_action = tbn_pkg::PACT_STEP;
        end else begin
          r.prev_action = tbn_pkg::PACT_RESTART;
        end
        play_tmr = '0;
        prev_tmr = '0;
      end
    end
    prev_raw = praw;

    if (nraw != next_raw) next_tmr = '0;
    if (next_tmr >= dbnc_ms && nraw != next_stable) begin
      next_stable = nraw;
      if (nraw == tbn_pkg::LEVEL_HIGH) begin
        next_tmr = '0;
        track = (track + 1 >= cnt) ? 0 : track + 1;
        r.next_action = 1'b1;
      end
    end
    next_raw = nraw;

    r.track_index = track[tbn_pkg::IDX_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      dbnc_ms     = tbn_pkg::DEBOUNCE_RST;
      window_ms   = tbn_pkg::WINDOW_RST;
      tcount      = tbn_pkg::TCOUNT_RST;
      prev_raw    = tbn_pkg::LEVEL_HIGH;
      prev_stable = tbn_pkg::LEVEL_HIGH;
      prev_tmr    = '0;
      next_raw    = tbn_pkg::LEVEL_HIGH;
      next_stable = tbn_pkg::LEVEL_HIGH;
      next_tmr    = '0;
      play_tmr    = '0;
      track       = 0;
      results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          tbn_pkg::REG_DEBOUNCE: dbnc_ms   = pwdata[tbn_pkg::TIMER_W-1:0];
          tbn_pkg::REG_WINDOW:   window_ms = pwdata[tbn_pkg::TIMER_W-1:0];
          tbn_pkg::REG_TCOUNT:   tcount    = pwdata[tbn_pkg::TC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        results_due.push_back(next_track_result(in_prev_level, in_next_level));
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result transfer with nothing expected, index",
                          int'(out_track_index), 0);
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (want.prev_action == tbn_pkg::PACT_STEP) steps_back++;
          if (want.prev_action == tbn_pkg::PACT_RESTART) restarts++;
          if (want.next_action) steps_fwd++;
          if (out_prev_action !== want.prev_action) begin
            report_mismatch("prev_action", int'(out_prev_action), int'(want.prev_action));
          end
          if (out_next_action !== want.next_action) begin
            report_mismatch("next_action", int'(out_next_action), int'(want.next_action));
          end
          if (out_track_index !== want.track_index) begin
            report_mismatch("track_index", int'(out_track_index), int'(want.track_index));
          end
        end
      end
    end
    pending = results_due.size();
  end

endmodule

@@ test/tb_track_button_navigator.sv @@
`timescale 1ns / 1ps
// top of the track_button_navigator testbench: clock, reset, tick and apb stimulus
// and the verdict; depends on tbn_pkg, track_nav_check and the block itself
module tb_track_button_navigator;

  localparam logic [1:0] REG_UNMAPPED   = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_prev_level;
  logic in_next_level;
  logic out_valid;
  logic out_ready = 1'b0;
  tbn_pkg::pact_t out_prev_action;
  logic out_next_action;
  logic [tbn_pkg::IDX_W-1:0] out_track_index;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tbn_pkg::ADDR_W-1:0] paddr;
  logic [tbn_pkg::DATA_W-1:0] pwdata;
  logic [tbn_pkg::DATA_W-1:0] prdata;
  logic pready;

  int err_count;
  int pending;
  int results_checked;
  int steps_back;
  int restarts;
  int steps_fwd;

  logic idle_on  = 1'b1;
  logic stall_on = 1'b1;
  int   ticks_sent = 0;
  int   reg_writes = 0;
  int   cur_debounce;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  track_button_navigator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_prev_level   (in_prev_level),
    .in_next_level   (in_next_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_prev_action (out_prev_action),
    .out_next_action (out_next_action),
    .out_track_index (out_track_index),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  track_nav_check nav_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_prev_level   (in_prev_level),
    .in_next_level   (in_next_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_prev_action (out_prev_action),
    .out_next_action (out_next_action),
    .out_track_index (out_track_index),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .err_count       (err_count),
    .pending         (pending),
    .results_checked (results_checked),
    .steps_back      (steps_back),
    .restarts        (restarts),
    .steps_fwd       (steps_fwd)
  );

  always @(negedge clk) begin
    out_ready <= stall_on ? ($urandom_range(0, 99) >= 21) : 1'b1;
  end

  task automatic send_tick(input logic p, input logic n);
    while (idle_on && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_prev_level <= p;
    in_next_level <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  // press one or both buttons for a tick, then release
  task automatic tap(input logic p, input logic n);
    send_tick(p, n);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  function automatic int hold_len(input int d);
    if (d >= 30) return $urandom_range(1, 40);
    if ($urandom_range(0, 99) < 15) return $urandom_range(1, d + 1);
    return d + 1 + $urandom_range(0, 3);
  endfunction

  // one button gesture with optional bounce, or a burst of raw noise
  task automatic gesture();
    int   roll;
    int   sel;
    logic p_lvl;
    logic n_lvl;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      repeat ($urandom_range(1, 8))
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      sel   = $urandom_range(0, 2);
      p_lvl = (sel == 1);
      n_lvl = (sel == 0);
      if (roll < 45) begin
        repeat ($urandom_range(1, 3))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      repeat (hold_len(cur_debounce)) send_tick(p_lvl, n_lvl);
      if (roll < 45) begin
        repeat ($urandom_range(1, 3))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      repeat (hold_len(cur_debounce) + $urandom_range(0, 40)) send_tick(1'b1, 1'b1);
    end
  endtask

  task automatic run_phase(input int dbnc, input int win, input int tc, input int n);
    int stop_at;
    set_reg(tbn_pkg::REG_DEBOUNCE, dbnc);
    set_reg(tbn_pkg::REG_WINDOW, win);
    set_reg(tbn_pkg::REG_TCOUNT, tc);
    cur_debounce = dbnc;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 49) == 0) drain();
      gesture();
    end
  endtask

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("tb_track_button_navigator: done, errors");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_prev_level = 1'b1;
    in_next_level = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // immediate acceptance, wrap both ways, restart, both buttons in one tick
    set_reg(tbn_pkg::REG_DEBOUNCE, 0);
    set_reg(tbn_pkg::REG_WINDOW, 2);
    set_reg(tbn_pkg::REG_TCOUNT, 4);
    set_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    repeat (4) tap(1'b1, 1'b0);
    tap(1'b0, 1'b1);
    tap(1'b0, 1'b1);
    tap(1'b0, 1'b0);

    // track count out of range and index left beyond a lowered count
    set_reg(tbn_pkg::REG_TCOUNT, 1);
    tap(1'b1, 1'b0);
    set_reg(tbn_pkg::REG_WINDOW, 65535);
    set_reg(tbn_pkg::REG_TCOUNT, 128);
    tap(1'b0, 1'b1);
    set_reg(tbn_pkg::REG_TCOUNT, 3);
    tap(1'b1, 1'b0);
    set_reg(tbn_pkg::REG_TCOUNT, 200);
    tap(1'b0, 1'b1);
    set_reg(tbn_pkg::REG_TCOUNT, 3);
    tap(1'b0, 1'b1);
    set_reg(tbn_pkg::REG_TCOUNT, 0);
    tap(1'b1, 1'b0);

    run_phase(2, 20, 8, 180);
    run_phase(0, 0, 1, 130);
    run_phase($urandom_range(1, 6), $urandom_range(5, 60), $urandom_range(2, 128), 220);
    run_phase(1, 65535, 128, 180);
    run_phase(3, 30, 255, 130);
    run_phase(0, 15, 0, 130);
    run_phase($urandom_range(0, 8), $urandom_range(0, 80), $urandom_range(1, 128), 220);
    run_phase(65535, 0, 3, 40);

    // long hold with no idling, then a release of both past the window
    idle_on  = 1'b0;
    stall_on = 1'b0;
    set_reg(tbn_pkg::REG_DEBOUNCE, 60);
    set_reg(tbn_pkg::REG_WINDOW, 40);
    set_reg(tbn_pkg::REG_TCOUNT, 5);
    repeat (100) send_tick(1'b0, 1'b0);
    set_reg(tbn_pkg::REG_DEBOUNCE, 0);
    send_tick(1'b1, 1'b1);
    idle_on  = 1'b1;
    stall_on = 1'b1;

    drain();
    repeat (4) @(negedge clk);
    $display("covered %0d ticks and %0d register writes, extremes and an unmapped address",
             ticks_sent, reg_writes);
    $display("checked %0d results: %0d step-backs, %0d restarts, %0d step-forwards",
             results_checked, steps_back, restarts, steps_fwd);
    if (err_count == 0) begin
      $display("tb_track_button_navigator: done, clean");
    end else begin
      $display("tb_track_button_navigator: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/tbn_pkg.sv
src/track_button_navigator.sv
test/track_nav_check.sv
test/tb_track_button_navigator.sv
